[design/pvt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvt_pkg
// Shared constants and types of the pinned version table.
// ----------------------------------------------------------------------------
package pvt_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = IDX_W + 1;

	localparam logic [2:0] KIND_INIT   = 3'd0;
	localparam logic [2:0] KIND_SNAP   = 3'd1;
	localparam logic [2:0] KIND_TOGGLE = 3'd2;
	localparam logic [2:0] KIND_LOOKUP = 3'd3;
	localparam logic [2:0] KIND_FIND   = 3'd4;
	localparam logic [2:0] KIND_SHOULD = 3'd5;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_MISS = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	localparam logic [30:0] MIN_INTERVAL_RST = 31'd60;

	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] wa;
		logic [31:0]      wd_id;
		logic [31:0]      wd_time;
		logic [IDX_W-1:0] ra;
	} mem_req_t;

endpackage

[design/pinned_version_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pinned_version_table
// Ordered table of version entries with pin marks, oldest first.
// ----------------------------------------------------------------------------
// One word at a time. Init, snapshot into a table with room, lookup or toggle
// of the newest entry (id 0), should-snapshot and reserved kinds put their
// result straight into the output register on acceptance. Lookup and toggle
// by id, and find by time, walk the table one entry a cycle through the
// single read port of the store. A snapshot into a full table first walks
// the pin marks for the oldest unpinned entry, then moves each later entry
// down one slot a cycle through the same port; it reports a full status
// when every entry but the newest is pinned. A new word is taken only once
// the previous result has been taken.
module pinned_version_table (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  kind,
	input  logic [31:0] ver_id,
	input  logic [31:0] time_value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [31:0] found_id,
	output logic [31:0] found_time,
	output logic        pin_state,
	output logic [7:0]  slot_index,
	output logic        snapshot_due,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [30:0] cfg_data
);

	localparam int IW = pvt_pkg::IDX_W;
	localparam int CW = pvt_pkg::CNT_W;
	localparam int DEPTH = pvt_pkg::TABLE_DEPTH;

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_SCAN  = 3'b010,
		S_SHIFT = 3'b100
	} state_t;

	typedef enum logic [1:0] {
		M_LOOKUP,
		M_FIND,
		M_VICTIM
	} mode_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] id;
		logic [31:0] tm;
		logic        pin;
		logic [7:0]  slot;
		logic        due;
	} res_t;

	function automatic res_t mk_res(logic [1:0] st, logic [31:0] id, logic [31:0] tm,
		logic pin, logic [IW-1:0] slot, logic due);
		res_t r;
		r.status = st;
		r.id     = id;
		r.tm     = tm;
		r.pin    = pin;
		r.slot   = 8'(slot);
		r.due    = due;
		return r;
	endfunction

	state_t            state_q;
	mode_t             mode_q;
	logic              toggle_q;
	logic [31:0]       vid_q;
	logic [31:0]       tv_q;
	logic [IW-1:0]     idx_q;
	logic [CW-1:0]     left_q;
	logic              chk_vld_s1;
	logic [IW-1:0]     chk_idx_s1;
	logic [DEPTH-1:0]  pin_q;
	logic [CW-1:0]     count_q;
	logic [31:0]       newest_id_q;
	logic [31:0]       newest_time_q;
	logic [30:0]       min_q;
	logic              out_vld_q;
	res_t              res_q;

	pvt_pkg::mem_req_t req;
	logic [31:0]       rd_id;
	logic [31:0]       rd_time;

	logic              in_fire;
	logic              full;
	logic [IW-1:0]     last_idx;
	logic [31:0]       append_id;
	logic signed [33:0] diff;
	logic              due;
	logic              hit;

	pvt_store u_store (
		.clk     (clk),
		.req     (req),
		.rd_id   (rd_id),
		.rd_time (rd_time)
	);

	assign in_ready  = (state_q == S_IDLE) && !out_vld_q;
	assign in_fire   = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	assign full      = (count_q == CW'(DEPTH));
	assign last_idx  = IW'(count_q - CW'(1));
	assign append_id = (count_q == '0) ? 32'd1 : newest_id_q + 32'd1;
	assign diff      = $signed({2'b00, time_value}) - $signed({2'b00, newest_time_q});
	assign due       = !(diff < $signed({3'b000, min_q}));

	always_comb begin
		case (mode_q)
			M_LOOKUP: hit = (rd_id == vid_q);
			M_FIND:   hit = (rd_time <= tv_q);
			M_VICTIM: hit = !pin_q[chk_idx_s1];
			default:  hit = 1'b0;
		endcase
	end

	always_comb begin
		req         = '0;
		req.ra      = idx_q;
		req.wd_time = time_value;
		req.wd_id   = append_id;
		req.wa      = count_q[IW-1:0];
		case (state_q)
			S_IDLE: begin
				if (in_fire && kind == pvt_pkg::KIND_INIT) begin
					req.we    = 1'b1;
					req.wa    = '0;
					req.wd_id = 32'd1;
				end else if (in_fire && kind == pvt_pkg::KIND_SNAP && !full) begin
					req.we = 1'b1;
				end
			end
			S_SHIFT: begin
				if (chk_vld_s1) begin
					req.we      = 1'b1;
					req.wa      = chk_idx_s1;
					req.wd_id   = rd_id;
					req.wd_time = rd_time;
				end else if (left_q == '0) begin
					req.we      = 1'b1;
					req.wa      = IW'(DEPTH - 1);
					req.wd_time = tv_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			mode_q        <= M_LOOKUP;
			toggle_q      <= 1'b0;
			vid_q         <= '0;
			tv_q          <= '0;
			idx_q         <= '0;
			left_q        <= '0;
			chk_vld_s1    <= 1'b0;
			chk_idx_s1    <= '0;
			pin_q         <= '0;
			count_q       <= '0;
			newest_id_q   <= '0;
			newest_time_q <= '0;
			min_q         <= pvt_pkg::MIN_INTERVAL_RST;
			out_vld_q     <= 1'b0;
			res_q         <= '0;
		end else begin
			if (cfg_valid) begin
				min_q <= cfg_data;
			end
			if (out_vld_q && out_ready) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					chk_vld_s1 <= 1'b0;
					if (in_fire) begin
						vid_q    <= ver_id;
						tv_q     <= time_value;
						toggle_q <= (kind == pvt_pkg::KIND_TOGGLE);
						case (kind)
							pvt_pkg::KIND_INIT: begin
								pin_q         <= '0;
								count_q       <= CW'(1);
								newest_id_q   <= 32'd1;
								newest_time_q <= time_value;
								out_vld_q     <= 1'b1;
								res_q <= mk_res(pvt_pkg::ST_OK, 32'd1, time_value, 1'b0,
									'0, 1'b0);
							end
							pvt_pkg::KIND_SNAP: begin
								if (!full) begin
									pin_q[count_q[IW-1:0]] <= 1'b0;
									count_q       <= count_q + CW'(1);
									newest_id_q   <= append_id;
									newest_time_q <= time_value;
									out_vld_q     <= 1'b1;
									res_q <= mk_res(pvt_pkg::ST_OK, append_id, time_value,
										1'b0, count_q[IW-1:0], 1'b0);
								end else begin
									mode_q  <= M_VICTIM;
									idx_q   <= '0;
									left_q  <= CW'(DEPTH - 1);
									state_q <= S_SCAN;
								end
							end
							pvt_pkg::KIND_TOGGLE, pvt_pkg::KIND_LOOKUP: begin
								if (count_q == '0) begin
									out_vld_q <= 1'b1;
									res_q <= mk_res(pvt_pkg::ST_MISS, '0, '0, 1'b0, '0, 1'b0);
								end else if (ver_id == '0) begin
									if (kind == pvt_pkg::KIND_TOGGLE) begin
										pin_q[last_idx] <= !pin_q[last_idx];
									end
									out_vld_q <= 1'b1;
									res_q <= mk_res(pvt_pkg::ST_OK, newest_id_q, newest_time_q,
										pin_q[last_idx] ^ (kind == pvt_pkg::KIND_TOGGLE),
										last_idx, 1'b0);
								end else begin
									mode_q  <= M_LOOKUP;
									idx_q   <= '0;
									left_q  <= count_q;
									state_q <= S_SCAN;
								end
							end
							pvt_pkg::KIND_FIND: begin
								if (count_q == '0) begin
									out_vld_q <= 1'b1;
									res_q <= mk_res(pvt_pkg::ST_MISS, '0, '0, 1'b0, '0, 1'b0);
								end else begin
									mode_q  <= M_FIND;
									idx_q   <= last_idx;
									left_q  <= count_q;
									state_q <= S_SCAN;
								end
							end
							pvt_pkg::KIND_SHOULD: begin
								out_vld_q <= 1'b1;
								if (count_q == '0) begin
									res_q <= mk_res(pvt_pkg::ST_OK, '0, '0, 1'b0, '0, 1'b1);
								end else begin
									res_q <= mk_res(pvt_pkg::ST_OK, newest_id_q, newest_time_q,
										pin_q[last_idx], last_idx, due);
								end
							end
							default: begin
								out_vld_q <= 1'b1;
								res_q <= mk_res(pvt_pkg::ST_MISS, '0, '0, 1'b0, '0, 1'b0);
							end
						endcase
					end
				end
				S_SCAN: begin
					// read ahead one entry while the previous one is checked
					chk_vld_s1 <= (left_q != '0);
					chk_idx_s1 <= idx_q;
					if (left_q != '0) begin
						left_q <= left_q - CW'(1);
						idx_q  <= (mode_q == M_FIND) ? idx_q - IW'(1) : idx_q + IW'(1);
					end
					if (chk_vld_s1 && hit) begin
						chk_vld_s1 <= 1'b0;
						case (mode_q)
							M_VICTIM: begin
								idx_q   <= chk_idx_s1 + IW'(1);
								left_q  <= CW'(DEPTH - 1) - {1'b0, chk_idx_s1};
								state_q <= S_SHIFT;
							end
							M_LOOKUP: begin
								pin_q[chk_idx_s1] <= pin_q[chk_idx_s1] ^ toggle_q;
								out_vld_q <= 1'b1;
								res_q <= mk_res(pvt_pkg::ST_OK, rd_id, rd_time,
									pin_q[chk_idx_s1] ^ toggle_q, chk_idx_s1, 1'b0);
								state_q <= S_IDLE;
							end
							default: begin
								out_vld_q <= 1'b1;
								res_q <= mk_res(pvt_pkg::ST_OK, rd_id, rd_time,
									pin_q[chk_idx_s1], chk_idx_s1, 1'b0);
								state_q <= S_IDLE;
							end
						endcase
					end else if (chk_vld_s1 && left_q == '0) begin
						chk_vld_s1 <= 1'b0;
						out_vld_q  <= 1'b1;
						res_q <= mk_res((mode_q == M_VICTIM) ? pvt_pkg::ST_FULL :
							pvt_pkg::ST_MISS, '0, '0, 1'b0, '0, 1'b0);
						state_q <= S_IDLE;
					end
				end
				S_SHIFT: begin
					chk_vld_s1 <= (left_q != '0);
					chk_idx_s1 <= idx_q - IW'(1);
					if (left_q != '0) begin
						pin_q[idx_q - IW'(1)] <= pin_q[idx_q];
						left_q <= left_q - CW'(1);
						idx_q  <= idx_q + IW'(1);
					end else if (!chk_vld_s1) begin
						// last slot freed: append the new entry there
						pin_q[IW'(DEPTH - 1)] <= 1'b0;
						newest_id_q   <= append_id;
						newest_time_q <= tv_q;
						out_vld_q     <= 1'b1;
						res_q <= mk_res(pvt_pkg::ST_OK, append_id, tv_q, 1'b0,
							IW'(DEPTH - 1), 1'b0);
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid    = out_vld_q;
	assign status       = res_q.status;
	assign found_id     = res_q.id;
	assign found_time   = res_q.tm;
	assign pin_state    = res_q.pin;
	assign slot_index   = res_q.slot;
	assign snapshot_due = res_q.due;

endmodule

[design/pvt_store.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvt_store
// Id and timestamp storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module pvt_store (
	input  logic              clk,
	input  pvt_pkg::mem_req_t req,
	output logic [31:0]       rd_id,
	output logic [31:0]       rd_time
);

	logic [31:0] ids_mem   [pvt_pkg::TABLE_DEPTH];
	logic [31:0] times_mem [pvt_pkg::TABLE_DEPTH];

	always_ff @(posedge clk) begin
		if (req.we) begin
			ids_mem[req.wa]   <= req.wd_id;
			times_mem[req.wa] <= req.wd_time;
		end
		rd_id   <= ids_mem[req.ra];
		rd_time <= times_mem[req.ra];
	end

endmodule
